FILE: rtl/rbad_pkg.sv
package rbad_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_YY = 3'd1;
  localparam logic [2:0] REG_ZZ = 3'd2;
  localparam logic [2:0] REG_XY = 3'd3;
  localparam logic [2:0] REG_XZ = 3'd4;
  localparam logic [2:0] REG_YZ = 3'd5;

  localparam logic signed [31:0] INERTIA_ONE = 32'sd65536;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  // Results that ride along the divider next to the quotients
  typedef struct packed {
    logic [3:0][31:0] qdot;
    logic             sing;
  } rbad_side_t;

  // Q16.16 product: exact 64-bit product, arithmetic shift by 16
  function automatic logic signed [47:0] pm(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat(input logic signed [51:0] x);
    logic signed [31:0] r;
    if (x > SAT_MAX) r = SAT_MAX[31:0];
    else if (x < SAT_MIN) r = SAT_MIN[31:0];
    else r = x[31:0];
    return r;
  endfunction

endpackage

FILE: rtl/rbad_div.sv
module rbad_div
  import rbad_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0][63:0] num,
  input  logic [2:0]       neg,
  input  logic [47:0]      dmag,
  input  rbad_side_t       side_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0][31:0] accel,
  output rbad_side_t       side_out
);

  localparam int STEPS = 32;

  logic             v     [STEPS+1];
  logic             en    [STEPS+2];
  logic [2:0][63:0] rem   [STEPS+1];
  logic [2:0][31:0] quo   [STEPS+1];
  logic [2:0]       sgn   [STEPS+1];
  logic [2:0]       ovf   [STEPS+1];
  logic [47:0]      dm    [STEPS+1];
  rbad_side_t       sd    [STEPS+1];

  logic [2:0][31:0] accel_next;

  // Stage moves when empty or when the next one moves
  assign en[STEPS+1] = !out_valid || !out_stall;
  generate
    for (genvar k = 0; k <= STEPS; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate
  assign in_stall = !en[0];

  // Capture operands and flag quotients that cannot fit in 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en[0]) begin
      v[0] <= in_valid;
    end
    if (en[0]) begin
      rem[0] <= num;
      quo[0] <= '0;
      sgn[0] <= neg;
      dm[0]  <= dmag;
      sd[0]  <= side_in;
      for (int i = 0; i < 3; i++) begin
        ovf[0][i] <= {16'b0, num[i]} >= {dmag, 32'b0};
      end
    end
  end

  // One restoring quotient bit per stage, most significant first
  generate
    for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int B = STEPS - k;
      logic [79:0] shd;
      assign shd = {32'b0, dm[k-1]} << B;

      always_ff @(posedge clk) begin
        if (rst) begin
          v[k] <= 1'b0;
        end else if (en[k]) begin
          v[k] <= v[k-1];
        end
        if (en[k]) begin
          sgn[k] <= sgn[k-1];
          ovf[k] <= ovf[k-1];
          dm[k]  <= dm[k-1];
          sd[k]  <= sd[k-1];
          for (int i = 0; i < 3; i++) begin
            if ({16'b0, rem[k-1][i]} >= shd) begin
              rem[k][i]    <= rem[k-1][i] - shd[63:0];
              quo[k][i]    <= quo[k-1][i] | (32'd1 << B);
            end else begin
              rem[k][i]    <= rem[k-1][i];
              quo[k][i]    <= quo[k-1][i];
            end
          end
        end
      end
    end
  endgenerate

  // Apply sign, saturate, zero on a singular tensor
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd[STEPS].sing) begin
        accel_next[i] = '0;
      end else if (sgn[STEPS][i]) begin
        if (ovf[STEPS][i] || quo[STEPS][i] > 32'h8000_0000) accel_next[i] = 32'h8000_0000;
        else accel_next[i] = 32'd0 - quo[STEPS][i];
      end else begin
        if (ovf[STEPS][i] || quo[STEPS][i] > 32'h7fff_ffff) accel_next[i] = 32'h7fff_ffff;
        else accel_next[i] = quo[STEPS][i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en[STEPS+1]) begin
      out_valid <= v[STEPS];
    end
    if (en[STEPS+1]) begin
      accel    <= accel_next;
      side_out <= sd[STEPS];
    end
  end

endmodule

FILE: rtl/rigid_body_attitude_derivative.sv
// Rigid-body attitude derivative. Each transfer of body rates, quaternion and
// torque yields one result: angular acceleration J^-1(M - w x Jw), applied as
// adj(J)*rhs/det(J) with the quotient truncated toward zero and saturated, the
// quaternion rate 0.5*Omega(w)*q, and a singular flag that zeroes the
// accelerations when det(J) is zero. All values are signed Q16.16, but the
// quaternion inputs are signed Q2.16. The block takes one item per clock
// when result_stall does not hold it back; the pipeline has seven multiply/sum
// stages, a 33-stage pipelined divider (operand capture, then one quotient bit
// per stage) and the output register. The six inertia registers may be written
// only while no item is in flight; cfg_ready is always high.
module rigid_body_attitude_derivative
  import rbad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [31:0] rate_x,
  input  logic [31:0] rate_y,
  input  logic [31:0] rate_z,
  input  logic [17:0] quat_x,
  input  logic [17:0] quat_y,
  input  logic [17:0] quat_z,
  input  logic [17:0] quat_w,
  input  logic [31:0] torque_x,
  input  logic [31:0] torque_y,
  input  logic [31:0] torque_z,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] accel_x,
  output logic [31:0] accel_y,
  output logic [31:0] accel_z,
  output logic [31:0] qdot_x,
  output logic [31:0] qdot_y,
  output logic [31:0] qdot_z,
  output logic [31:0] qdot_w,
  output logic        singular
);

  logic signed [31:0] ixx, iyy, izz, ixy, ixz, iyz;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ixx <= INERTIA_ONE;
      iyy <= INERTIA_ONE;
      izz <= INERTIA_ONE;
      ixy <= '0;
      ixz <= '0;
      iyz <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_XX:  ixx <= cfg_data;
        REG_YY:  iyy <= cfg_data;
        REG_ZZ:  izz <= cfg_data;
        REG_XY:  ixy <= cfg_data;
        REG_XZ:  ixz <= cfg_data;
        REG_YZ:  iyz <= cfg_data;
        default: ;
      endcase
    end
  end

  logic v [1:7];
  logic en [1:8];
  logic div_stall;

  assign en[8] = !div_stall;
  generate
    for (genvar k = 1; k <= 7; k++) begin : g_en
      assign en[k] = !v[k] || en[k+1];
    end
  endgenerate
  assign item_stall = !en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= 7; k++) v[k] <= 1'b0;
    end else begin
      if (en[1]) v[1] <= item_valid;
      for (int k = 2; k <= 7; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: all first-level products
  logic signed [31:0] s1_w [3];
  logic signed [31:0] s1_m [3];
  logic signed [47:0] s1_ph [9];
  logic signed [47:0] s1_pa [12];
  logic signed [49:0] s1_pq [12];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_w[0] <= rate_x;   s1_w[1] <= rate_y;   s1_w[2] <= rate_z;
      s1_m[0] <= torque_x; s1_m[1] <= torque_y; s1_m[2] <= torque_z;
      s1_ph[0] <= pm(ixx, rate_x); s1_ph[1] <= pm(ixy, rate_y); s1_ph[2] <= pm(ixz, rate_z);
      s1_ph[3] <= pm(ixy, rate_x); s1_ph[4] <= pm(iyy, rate_y); s1_ph[5] <= pm(iyz, rate_z);
      s1_ph[6] <= pm(ixz, rate_x); s1_ph[7] <= pm(iyz, rate_y); s1_ph[8] <= pm(izz, rate_z);
      s1_pa[0]  <= pm(iyy, izz); s1_pa[1]  <= pm(iyz, iyz);
      s1_pa[2]  <= pm(ixx, izz); s1_pa[3]  <= pm(ixz, ixz);
      s1_pa[4]  <= pm(ixx, iyy); s1_pa[5]  <= pm(ixy, ixy);
      s1_pa[6]  <= pm(ixz, iyz); s1_pa[7]  <= pm(ixy, izz);
      s1_pa[8]  <= pm(ixy, iyz); s1_pa[9]  <= pm(ixz, iyy);
      s1_pa[10] <= pm(ixy, ixz); s1_pa[11] <= pm(ixx, iyz);
      s1_pq[0]  <= $signed(rate_z) * $signed(quat_y);
      s1_pq[1]  <= $signed(rate_y) * $signed(quat_z);
      s1_pq[2]  <= $signed(rate_x) * $signed(quat_w);
      s1_pq[3]  <= $signed(rate_z) * $signed(quat_x);
      s1_pq[4]  <= $signed(rate_x) * $signed(quat_z);
      s1_pq[5]  <= $signed(rate_y) * $signed(quat_w);
      s1_pq[6]  <= $signed(rate_y) * $signed(quat_x);
      s1_pq[7]  <= $signed(rate_x) * $signed(quat_y);
      s1_pq[8]  <= $signed(rate_z) * $signed(quat_w);
      s1_pq[9]  <= $signed(rate_x) * $signed(quat_x);
      s1_pq[10] <= $signed(rate_y) * $signed(quat_y);
      s1_pq[11] <= $signed(rate_z) * $signed(quat_z);
    end
  end

  // Stage 2: momentum, cofactors, quaternion rate
  logic signed [31:0] s2_w [3];
  logic signed [31:0] s2_m [3];
  logic signed [31:0] s2_h [3];
  logic signed [31:0] s2_a [6];
  logic [3:0][31:0]   s2_qd;
  logic signed [31:0] h_next [3];
  logic signed [31:0] a_next [6];
  logic [3:0][31:0]   qd_next;
  logic signed [51:0] qsum [4];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      h_next[i] = sat(52'(s1_ph[3*i]) + 52'(s1_ph[3*i+1]) + 52'(s1_ph[3*i+2]));
    end
    for (int i = 0; i < 6; i++) begin
      a_next[i] = sat(52'(s1_pa[2*i]) - 52'(s1_pa[2*i+1]));
    end
    qsum[0] = 52'(s1_pq[0]) - 52'(s1_pq[1]) + 52'(s1_pq[2]);
    qsum[1] = 52'(s1_pq[4]) - 52'(s1_pq[3]) + 52'(s1_pq[5]);
    qsum[2] = 52'(s1_pq[6]) - 52'(s1_pq[7]) + 52'(s1_pq[8]);
    qsum[3] = -52'(s1_pq[9]) - 52'(s1_pq[10]) - 52'(s1_pq[11]);
    for (int i = 0; i < 4; i++) begin
      qd_next[i] = sat(qsum[i] >>> 17);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_w  <= s1_w;
      s2_m  <= s1_m;
      s2_h  <= h_next;
      s2_a  <= a_next;
      s2_qd <= qd_next;
    end
  end

  // Stage 3: cross products and determinant products
  // cofactor order: xx yy zz xy xz yz
  logic signed [31:0] s3_m [3];
  logic signed [31:0] s3_a [6];
  logic [3:0][31:0]   s3_qd;
  logic signed [47:0] s3_pc [6];
  logic signed [47:0] s3_pd [3];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_m  <= s2_m;
      s3_a  <= s2_a;
      s3_qd <= s2_qd;
      s3_pc[0] <= pm(s2_w[1], s2_h[2]); s3_pc[1] <= pm(s2_w[2], s2_h[1]);
      s3_pc[2] <= pm(s2_w[2], s2_h[0]); s3_pc[3] <= pm(s2_w[0], s2_h[2]);
      s3_pc[4] <= pm(s2_w[0], s2_h[1]); s3_pc[5] <= pm(s2_w[1], s2_h[0]);
      s3_pd[0] <= pm(ixx, s2_a[0]);
      s3_pd[1] <= pm(ixy, s2_a[3]);
      s3_pd[2] <= pm(ixz, s2_a[4]);
    end
  end

  // Stage 4: right-hand side and determinant
  logic signed [31:0] s4_a [6];
  logic [3:0][31:0]   s4_qd;
  logic signed [31:0] s4_r [3];
  logic signed [49:0] s4_det;
  logic signed [31:0] c_next [3];
  logic signed [31:0] r_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_next[i] = sat(52'(s3_pc[2*i]) - 52'(s3_pc[2*i+1]));
      r_next[i] = sat(52'(s3_m[i]) - 52'(c_next[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_a   <= s3_a;
      s4_qd  <= s3_qd;
      s4_r   <= r_next;
      s4_det <= 50'(s3_pd[0]) + 50'(s3_pd[1]) + 50'(s3_pd[2]);
    end
  end

  // Stage 5: adjugate times right-hand side, products
  logic signed [49:0] s5_det;
  logic [3:0][31:0]   s5_qd;
  logic signed [47:0] s5_pn [9];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_det <= s4_det;
      s5_qd  <= s4_qd;
      s5_pn[0] <= pm(s4_a[0], s4_r[0]); s5_pn[1] <= pm(s4_a[3], s4_r[1]);
      s5_pn[2] <= pm(s4_a[4], s4_r[2]);
      s5_pn[3] <= pm(s4_a[3], s4_r[0]); s5_pn[4] <= pm(s4_a[1], s4_r[1]);
      s5_pn[5] <= pm(s4_a[5], s4_r[2]);
      s5_pn[6] <= pm(s4_a[4], s4_r[0]); s5_pn[7] <= pm(s4_a[5], s4_r[1]);
      s5_pn[8] <= pm(s4_a[2], s4_r[2]);
    end
  end

  // Stage 6: numerator sums
  logic signed [49:0] s6_det;
  logic [3:0][31:0]   s6_qd;
  logic signed [49:0] s6_n [3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_det <= s5_det;
      s6_qd  <= s5_qd;
      for (int i = 0; i < 3; i++) begin
        s6_n[i] <= 50'(s5_pn[3*i]) + 50'(s5_pn[3*i+1]) + 50'(s5_pn[3*i+2]);
      end
    end
  end

  // Stage 7: magnitudes and signs for the divider
  logic [2:0][63:0] s7_num;
  logic [2:0]       s7_neg;
  logic [47:0]      s7_dmag;
  rbad_side_t       s7_side;
  logic [49:0]      nmag [3];
  logic [49:0]      dabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nmag[i] = s6_n[i][49] ? 50'd0 - s6_n[i] : s6_n[i];
    end
    dabs = s6_det[49] ? 50'd0 - s6_det : s6_det;
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) begin
        s7_num[i] <= {nmag[i][47:0], 16'b0};
        s7_neg[i] <= s6_n[i][49] ^ s6_det[49];
      end
      s7_dmag      <= dabs[47:0];
      s7_side.qdot <= s6_qd;
      s7_side.sing <= (s6_det == '0);
    end
  end

  logic [2:0][31:0] accel;
  rbad_side_t       side_out;

  rbad_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[7]),
    .in_stall  (div_stall),
    .num       (s7_num),
    .neg       (s7_neg),
    .dmag      (s7_dmag),
    .side_in   (s7_side),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .accel     (accel),
    .side_out  (side_out)
  );

  assign accel_x  = accel[0];
  assign accel_y  = accel[1];
  assign accel_z  = accel[2];
  assign qdot_x   = side_out.qdot[0];
  assign qdot_y   = side_out.qdot[1];
  assign qdot_z   = side_out.qdot[2];
  assign qdot_w   = side_out.qdot[3];
  assign singular = side_out.sing;

endmodule

FILE: test/rbad_checker.sv
module rbad_checker
  import rbad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic [31:0] rate_x,
  input  logic [31:0] rate_y,
  input  logic [31:0] rate_z,
  input  logic [17:0] quat_x,
  input  logic [17:0] quat_y,
  input  logic [17:0] quat_z,
  input  logic [17:0] quat_w,
  input  logic [31:0] torque_x,
  input  logic [31:0] torque_y,
  input  logic [31:0] torque_z,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [31:0] accel_x,
  input  logic [31:0] accel_y,
  input  logic [31:0] accel_z,
  input  logic [31:0] qdot_x,
  input  logic [31:0] qdot_y,
  input  logic [31:0] qdot_z,
  input  logic [31:0] qdot_w,
  input  logic        singular,
  output int          mismatches,
  output int          in_flight
);

  typedef struct {
    logic [31:0] ax, ay, az;
    logic [31:0] qx, qy, qz, qw;
    logic        sing;
  } deriv_t;

  deriv_t derivs_due[$];
  longint j_xx, j_yy, j_zz, j_xy, j_xz, j_yz;
  int unsigned n_results;

  // Q16.16 product, floor shift
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Quotient (n << 16) / d, truncated toward zero, then clamped
  function automatic longint qdivide(longint n, longint d);
    logic signed [127:0] num, den, q;
    num = n;
    num = num <<< 16;
    den = d;
    q = num / den;
    if (q > 128'sd2147483647) return 64'sd2147483647;
    if (q < -128'sd2147483648) return -64'sd2147483648;
    return longint'(q);
  endfunction

  function automatic deriv_t attitude_deriv();
    deriv_t r;
    longint wx, wy, wz, qx, qy, qz, qw, mx, my, mz;
    longint hx, hy, hz, cx, cy, cz, rx, ry, rz;
    longint cxx, cyy, czz, cxy, cxz, cyz, det;
    wx = longint'($signed(rate_x));
    wy = longint'($signed(rate_y));
    wz = longint'($signed(rate_z));
    qx = longint'($signed(quat_x));
    qy = longint'($signed(quat_y));
    qz = longint'($signed(quat_z));
    qw = longint'($signed(quat_w));
    mx = longint'($signed(torque_x));
    my = longint'($signed(torque_y));
    mz = longint'($signed(torque_z));
    // angular momentum, gyroscopic term, right-hand side
    hx = clamp32(qmul(j_xx, wx) + qmul(j_xy, wy) + qmul(j_xz, wz));
    hy = clamp32(qmul(j_xy, wx) + qmul(j_yy, wy) + qmul(j_yz, wz));
    hz = clamp32(qmul(j_xz, wx) + qmul(j_yz, wy) + qmul(j_zz, wz));
    cx = clamp32(qmul(wy, hz) - qmul(wz, hy));
    cy = clamp32(qmul(wz, hx) - qmul(wx, hz));
    cz = clamp32(qmul(wx, hy) - qmul(wy, hx));
    rx = clamp32(mx - cx);
    ry = clamp32(my - cy);
    rz = clamp32(mz - cz);
    // adjugate and determinant of the inertia
    cxx = clamp32(qmul(j_yy, j_zz) - qmul(j_yz, j_yz));
    cyy = clamp32(qmul(j_xx, j_zz) - qmul(j_xz, j_xz));
    czz = clamp32(qmul(j_xx, j_yy) - qmul(j_xy, j_xy));
    cxy = clamp32(qmul(j_xz, j_yz) - qmul(j_xy, j_zz));
    cxz = clamp32(qmul(j_xy, j_yz) - qmul(j_xz, j_yy));
    cyz = clamp32(qmul(j_xy, j_xz) - qmul(j_xx, j_yz));
    det = qmul(j_xx, cxx) + qmul(j_xy, cxy) + qmul(j_xz, cxz);
    r.sing = (det == 0);
    r.ax = '0;
    r.ay = '0;
    r.az = '0;
    if (!r.sing) begin
      r.ax = 32'(qdivide(qmul(cxx, rx) + qmul(cxy, ry) + qmul(cxz, rz), det));
      r.ay = 32'(qdivide(qmul(cxy, rx) + qmul(cyy, ry) + qmul(cyz, rz), det));
      r.az = 32'(qdivide(qmul(cxz, rx) + qmul(cyz, ry) + qmul(czz, rz), det));
    end
    // quaternion rate, half folded into the shift
    r.qx = 32'(clamp32((wz * qy - wy * qz + wx * qw) >>> 17));
    r.qy = 32'(clamp32((-wz * qx + wx * qz + wy * qw) >>> 17));
    r.qz = 32'(clamp32((wy * qx - wx * qy + wz * qw) >>> 17));
    r.qw = 32'(clamp32((-wx * qx - wy * qy - wz * qz) >>> 17));
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("result %0d: %s got %h expected %h", n_results, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    deriv_t e;
    if (rst) begin
      j_xx <= 65536; j_yy <= 65536; j_zz <= 65536;
      j_xy <= 0; j_xz <= 0; j_yz <= 0;
      derivs_due.delete();
      mismatches = 0;
      n_results <= 0;
      in_flight <= 0;
    end else begin
      // track inertia writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_XX: j_xx <= longint'($signed(cfg_data));
          REG_YY: j_yy <= longint'($signed(cfg_data));
          REG_ZZ: j_zz <= longint'($signed(cfg_data));
          REG_XY: j_xy <= longint'($signed(cfg_data));
          REG_XZ: j_xz <= longint'($signed(cfg_data));
          REG_YZ: j_yz <= longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // predict on each input transfer
      if (item_valid && !item_stall) derivs_due.insert(derivs_due.size(), attitude_deriv());
      // compare each output transfer with the oldest prediction
      if (result_valid && !result_stall) begin
        if (derivs_due.size() == 0) begin
          report("output with nothing outstanding, accel_x", accel_x, '0);
        end else begin
          e = derivs_due.pop_front();
          if (accel_x !== e.ax) report("accel_x", accel_x, e.ax);
          if (accel_y !== e.ay) report("accel_y", accel_y, e.ay);
          if (accel_z !== e.az) report("accel_z", accel_z, e.az);
          if (qdot_x !== e.qx) report("qdot_x", qdot_x, e.qx);
          if (qdot_y !== e.qy) report("qdot_y", qdot_y, e.qy);
          if (qdot_z !== e.qz) report("qdot_z", qdot_z, e.qz);
          if (qdot_w !== e.qw) report("qdot_w", qdot_w, e.qw);
          if (singular !== e.sing) report("singular", 32'(singular), 32'(e.sing));
        end
        n_results <= n_results + 1;
      end
      in_flight <= derivs_due.size();
    end
  end

endmodule

FILE: test/testbench.sv
module testbench;
  import rbad_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int LATENCY = 41;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 215;

  logic        clk;
  logic        rst;
  logic        cfg_valid, cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        item_valid, item_stall;
  logic [31:0] rate_x, rate_y, rate_z;
  logic [17:0] quat_x, quat_y, quat_z, quat_w;
  logic [31:0] torque_x, torque_y, torque_z;
  logic        result_valid, result_stall;
  logic [31:0] accel_x, accel_y, accel_z;
  logic [31:0] qdot_x, qdot_y, qdot_z, qdot_w;
  logic        singular;
  int          mismatches, in_flight;
  int          cycles;
  logic        long_hold;

  rigid_body_attitude_derivative DUT (.*);
  rbad_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Q16.16 word: small, corner or fully random
  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
    if (r == 4) begin
      case ($urandom_range(4))
        0: return 32'h7fffffff;
        1: return 32'h80000000;
        2: return 32'h0;
        3: return 32'hffffffff;
        default: return 32'h00010000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [17:0] pick_quat();
    if ($urandom_range(9) == 0) return 18'($urandom);
    return 18'($signed($urandom_range(131072)) - 65536);
  endfunction

  // hold the item until the block takes it
  task automatic send_item(logic [31:0] wx, wy, wz, logic [17:0] qx, qy, qz, qw,
                           logic [31:0] mx, my, mz);
    bit taken;
    int gap;
    rate_x <= wx; rate_y <= wy; rate_z <= wz;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    torque_x <= mx; torque_y <= my; torque_z <= mz;
    item_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !item_stall;
      @(posedge clk);
    end while (!taken);
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random();
    send_item(pick_word(), pick_word(), pick_word(), pick_quat(), pick_quat(),
              pick_quat(), pick_quat(), pick_word(), pick_word(), pick_word());
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    bit taken;
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // drain the pipe, then load a full inertia tensor
  task automatic load_inertia(logic [31:0] xx, yy, zz, xy, xz, yz);
    item_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    write_reg(REG_XX, xx);
    write_reg(REG_YY, yy);
    write_reg(REG_ZZ, zz);
    write_reg(REG_XY, xy);
    write_reg(REG_XZ, xz);
    write_reg(REG_YZ, yz);
    write_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_diag();
    return $urandom_range(1 << 20, 1 << 14);
  endfunction

  function automatic logic [31:0] pick_cross();
    return 32'($signed($urandom_range(1 << 15)) - (1 << 14));
  endfunction

  // result side: random stalls, one long hold on request
  initial begin
    int r;
    bit held;
    held = 1'b0;
    result_stall = 1'b1;
    @(negedge rst);
    forever begin
      if (long_hold && !held) begin
        result_stall <= 1'b1;
        repeat (400) @(posedge clk);
        held = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        result_stall <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end else if (r < 95) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end else begin
        result_stall <= 1'b1;
        repeat ($urandom_range(40, 10)) @(posedge clk);
      end
    end
  end

  initial begin
    long_hold = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    item_valid = 1'b0;
    {rate_x, rate_y, rate_z, torque_x, torque_y, torque_z} = '0;
    {quat_x, quat_y, quat_z, quat_w} = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners at the reset inertia
    send_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h10000, 18'h10000,
              18'h10000, 18'h10000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000, 32'h80000000, 18'h30000, 18'h30000,
              18'h30000, 18'h30000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 18'h30000, 18'h10000,
              18'h30000, 18'h10000, 32'h80000000, 32'h7fffffff, 0);
    send_item(32'h00010000, 0, 0, 0, 0, 0, 18'h10000, 0, 0, 0);
    send_item(0, 32'h00010000, 0, 0, 18'h10000, 0, 0, 32'h00010000, 0, 0);
    send_item(0, 0, 32'h00010000, 18'h10000, 0, 0, 0, 0, 0, 32'hffff0000);
    // quaternion beyond unit range, and the 18-bit extremes
    send_item(32'h00020000, 32'hfffe0000, 32'h00030000, 18'h1ffff, 18'h20000,
              18'h1ffff, 18'h20000, 0, 0, 0);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 18'h1ffff, 18'h1ffff,
              18'h1ffff, 18'h1ffff, 0, 0, 0);
    send_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 18'h3ffff, 18'h3ffff,
              18'h3ffff, 18'h3ffff, 32'hffffffff, 32'h1, 32'hffffffff);
    for (int i = 0; i < 12; i++) send_random();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_inertia(pick_diag(), pick_diag(), pick_diag(), 0, 0, 0);
        1: load_inertia(pick_diag(), pick_diag(), pick_diag(),
                        pick_cross(), pick_cross(), pick_cross());
        2: load_inertia(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        3: load_inertia(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000);
        4: load_inertia(0, 0, 0, 0, 0, 0);
        5: load_inertia(0, pick_diag(), pick_diag(), 0, 0, 0);
        6: load_inertia($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        7: load_inertia(32'h00010000, 32'h00010000, 32'h00010000,
                        32'h00010000, 32'h00010000, 32'h00010000);
        default: load_inertia(32'h7fffffff, 32'h80000000, 32'h00000001,
                              32'h80000000, 32'h7fffffff, 32'hffffffff);
      endcase
      if (ph == 1) long_hold = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_random();
    end
    item_valid <= 1'b0;

    // drain, then allow the pipeline to settle
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && in_flight == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
